// ===== design/bmd_pkg.sv =====
// Types, constants and message helpers shared by the BLE-MIDI packet decoder.
package bmd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_STAMP  = 3'd1,
    PH_STATUS = 3'd2,
    PH_DATA   = 3'd3,
    PH_IGNORE = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] length;
    logic [6:0] data_second;
    logic [6:0] data_first;
    logic [7:0] status;
  } msg_t;

  typedef struct packed {
    logic valid;
    msg_t msg;
  } res_t;

  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_AT   = 4'hA;
  localparam logic [3:0] HI_CONTROL   = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CHAN_AT   = 4'hD;
  localparam logic [3:0] HI_PITCH     = 4'hE;

  localparam logic [7:0] SYS_MTC      = 8'hF1;
  localparam logic [7:0] SYS_SONG_POS = 8'hF2;
  localparam logic [7:0] SYS_SONG_SEL = 8'hF3;
  localparam logic [7:0] SYS_TUNE     = 8'hF6;
  localparam logic [7:0] RT_CLOCK     = 8'hF8;
  localparam logic [7:0] RT_START     = 8'hFA;
  localparam logic [7:0] RT_CONT      = 8'hFB;
  localparam logic [7:0] RT_STOP      = 8'hFC;
  localparam logic [7:0] RT_SENSE     = 8'hFE;
  localparam logic [7:0] RT_RESET     = 8'hFF;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  function automatic logic is_pair_type(input logic [7:0] st);
    case (st[7:4]) inside
      HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CONTROL, HI_PITCH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_single_type(input logic [7:0] st);
    case (st[7:4]) inside
      HI_PROGRAM, HI_CHAN_AT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic msg_t make_msg(input logic [7:0] st, input logic [6:0] d1,
                                    input logic [6:0] d2, input logic [1:0] len);
    msg_t m;
    m.status      = st;
    m.data_first  = d1;
    m.data_second = d2;
    m.length      = len;
    return m;
  endfunction

  // Message, if any, given when a run closes with the held status and count.
  function automatic res_t end_run(input logic [7:0] st, input logic [2:0] cnt,
                                   input logic [6:0] d1, input logic [6:0] d2);
    res_t r;
    r.valid = 1'b0;
    r.msg   = make_msg(st, d1, d2, LEN_THREE);
    if (is_pair_type(st)) begin
      r.valid = (cnt <= 3'd2);
    end else if (is_single_type(st)) begin
      r.valid = (cnt == 3'd0);
      r.msg   = make_msg(st, 7'd0, 7'd0, LEN_TWO);
    end else if (cnt <= 3'd2) begin
      case (st) inside
        SYS_SONG_POS: begin
          r.valid = 1'b1;
        end
        SYS_MTC, SYS_SONG_SEL: begin
          r.valid = 1'b1;
          r.msg   = make_msg(st, d1, 7'd0, LEN_TWO);
        end
        SYS_TUNE, RT_CLOCK, RT_START, RT_CONT, RT_STOP, RT_SENSE, RT_RESET: begin
          r.valid = 1'b1;
          r.msg   = make_msg(st, 7'd0, 7'd0, LEN_ONE);
        end
        default: begin
          r.valid = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== design/ble_midi_packet_decoder_top.sv =====
// BLE-MIDI packet decoder: turns packet bytes into MIDI messages.
// One packet byte is taken per cycle when the input is not held off and gives at
// most one MIDI message, which is registered and appears on the output in the
// cycle after the byte is accepted. All decoding of a byte is combinational against
// the held packet state. The input is held off only while a message waits unread in
// the output register, and a new byte is taken in the same cycle as that message
// leaves, so the sustained rate is one byte per cycle whenever the output side keeps up.
module ble_midi_packet_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // packet_byte
  input  logic        s_axis_tlast,   // end_of_packet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // msg_status, msg_data_first, msg_data_second,
                                      // msg_length
);
  import bmd_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] held_status, held_status_next;
  logic [2:0] run_count, run_count_next;
  logic [6:0] held_first, held_first_next;
  logic [6:0] held_second, held_second_next;
  logic       out_valid;
  msg_t       out_msg;

  logic       accept;
  logic [7:0] b;
  logic       eop;
  logic [2:0] cnt_inc;
  logic       add_emit;
  msg_t       add_msg;
  res_t       res, end_res;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign eop           = s_axis_tlast;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_msg;
  assign cnt_inc       = (run_count >= 3'd6) ? 3'd5 : run_count + 3'd1;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HEADER: phase_next = PH_STAMP;
      PH_STAMP:  phase_next = PH_STATUS;
      PH_STATUS: phase_next = b[7] ? PH_DATA : PH_IGNORE;
      PH_DATA:   phase_next = b[7] ? PH_STATUS : PH_DATA;
      default:   phase_next = phase;
    endcase
    if (eop) begin
      phase_next = PH_HEADER;
    end
  end

  always_comb begin
    held_status_next = held_status;
    run_count_next   = run_count;
    held_first_next  = held_first;
    held_second_next = held_second;
    add_emit         = 1'b0;
    add_msg          = make_msg(held_status, held_first, held_second, LEN_THREE);
    res              = '0;
    end_res          = '0;
    case (phase)
      PH_STATUS: begin
        if (b[7]) begin
          held_status_next = b;
          run_count_next   = 3'd0;
          held_first_next  = 7'd0;
          held_second_next = 7'd0;
          end_res          = end_run(b, 3'd0, 7'd0, 7'd0);
          res.valid        = eop && end_res.valid;
          res.msg          = end_res.msg;
        end
      end
      PH_DATA: begin
        if (b[7]) begin
          res = end_run(held_status, run_count, held_first, held_second);
        end else begin
          run_count_next = cnt_inc;
          if (is_single_type(held_status)) begin
            add_emit = 1'b1;
            add_msg  = make_msg(held_status, b[6:0], 7'd0, LEN_TWO);
          end else if (!is_pair_type(held_status)) begin
            if (cnt_inc == 3'd1) begin
              held_first_next = b[6:0];
            end else if (cnt_inc == 3'd2) begin
              held_second_next = b[6:0];
            end
          end else if (cnt_inc == 3'd1 || cnt_inc == 3'd5) begin
            held_first_next = b[6:0];
          end else if (cnt_inc == 3'd2) begin
            held_second_next = b[6:0];
          end else if (cnt_inc == 3'd3) begin
            add_emit        = 1'b1;
            held_first_next = b[6:0];
          end else begin
            add_emit         = 1'b1;
            held_second_next = b[6:0];
            add_msg          = make_msg(held_status, held_first, b[6:0], LEN_THREE);
          end
          end_res = end_run(held_status, run_count_next, held_first_next,
                            held_second_next);
          if (add_emit) begin
            res.valid = 1'b1;
            res.msg   = add_msg;
          end else begin
            res.valid = eop && end_res.valid;
            res.msg   = end_res.msg;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      held_status <= 8'd0;
      run_count   <= 3'd0;
      held_first  <= 7'd0;
      held_second <= 7'd0;
      out_valid   <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      held_status <= held_status_next;
      run_count   <= run_count_next;
      held_first  <= held_first_next;
      held_second <= held_second_next;
      out_valid   <= res.valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_msg <= res.msg;
    end
  end

endmodule

// ===== sim/tb_ble_midi_packet_decoder_top.sv =====
// Self-checking testbench for the BLE-MIDI packet decoder, with an in-line message predictor.
`timescale 1ns / 1ps

module tb_ble_midi_packet_decoder_top;
  import bmd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS = 440;
  localparam logic [7:0] SYS_UNDEFINED = 8'hF4;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  word_t  pending_words[$];
  msg_t   expected_msgs[$];
  int     words_queued = 0;
  int     words_taken = 0;
  int     bad_count = 0;
  int     quiet_cycles = 0;
  int     send_idle_pct = 10;
  int     recv_idle_pct = 51;
  int     stall_left = 0;
  logic   stall_done = 1'b0;
  logic   word_taken_now = 1'b0;

  phase_t     decode_phase = PH_HEADER;
  logic [7:0] run_status = 8'h00;
  logic [2:0] run_len = 3'd0;
  logic [6:0] run_first = 7'd0;
  logic [6:0] run_second = 7'd0;

  ble_midi_packet_decoder_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic takes_pair(input logic [7:0] st);
    case (st[7:4])
      HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CONTROL, HI_PITCH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic takes_single(input logic [7:0] st);
    return (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_CHAN_AT);
  endfunction

  task automatic queue_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2,
                           input logic [1:0] len);
    msg_t m;
    m.status      = st;
    m.data_first  = d1;
    m.data_second = d2;
    m.length      = len;
    expected_msgs.push_back(m);
  endtask

  task automatic close_run();
    if (takes_pair(run_status)) begin
      if (run_len <= 3'd2) queue_msg(run_status, run_first, run_second, LEN_THREE);
    end else if (takes_single(run_status)) begin
      if (run_len == 3'd0) queue_msg(run_status, 7'd0, 7'd0, LEN_TWO);
    end else if (run_len <= 3'd2) begin
      case (run_status)
        SYS_SONG_POS: queue_msg(run_status, run_first, run_second, LEN_THREE);
        SYS_MTC, SYS_SONG_SEL: queue_msg(run_status, run_first, 7'd0, LEN_TWO);
        SYS_TUNE, RT_CLOCK, RT_START, RT_CONT, RT_STOP, RT_SENSE, RT_RESET:
          queue_msg(run_status, 7'd0, 7'd0, LEN_ONE);
        default: ;
      endcase
    end
  endtask

  // Running status: long pair runs alternate the count between 5 and 6 to keep parity.
  task automatic absorb_data(input logic [6:0] d);
    run_len = (run_len >= 3'd6) ? 3'd5 : run_len + 3'd1;
    if (takes_single(run_status)) begin
      queue_msg(run_status, d, 7'd0, LEN_TWO);
    end else if (!takes_pair(run_status)) begin
      if (run_len == 3'd1) run_first = d;
      else if (run_len == 3'd2) run_second = d;
    end else begin
      case (run_len)
        3'd1, 3'd5: run_first = d;
        3'd2: run_second = d;
        3'd3: begin
          queue_msg(run_status, run_first, run_second, LEN_THREE);
          run_first = d;
        end
        default: begin
          run_second = d;
          queue_msg(run_status, run_first, run_second, LEN_THREE);
        end
      endcase
    end
  endtask

  task automatic decode_word(input logic [7:0] b, input logic last);
    case (decode_phase)
      PH_HEADER: decode_phase = PH_STAMP;
      PH_STAMP: decode_phase = PH_STATUS;
      PH_STATUS: begin
        if (!b[7]) begin
          decode_phase = PH_IGNORE;
        end else begin
          run_status = b;
          run_len = 3'd0;
          run_first = 7'd0;
          run_second = 7'd0;
          decode_phase = PH_DATA;
          if (last) close_run();
        end
      end
      PH_DATA: begin
        if (b[7]) begin
          close_run();
          decode_phase = PH_STATUS;
        end else begin
          absorb_data(b[6:0]);
          if (last) close_run();
        end
      end
      default: ;
    endcase
    if (last) decode_phase = PH_HEADER;
  endtask

  task automatic push_word(input logic [7:0] b, input logic last);
    word_t w;
    w.value = b;
    w.last = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_random_packet();
    logic [7:0] pkt[$];
    logic [7:0] st;
    int shape;
    int runs;
    int k;
    int n;
    shape = $urandom_range(0, 99);
    pkt.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                              : {2'b10, 6'($urandom_range(0, 63))});
    if (shape < 80) begin
      pkt.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : {1'b1, 7'($urandom_range(0, 127))});
      runs = $urandom_range(1, 3);
      for (int r = 0; r < runs; r++) begin
        if (r > 0) pkt.push_back({1'b1, 7'($urandom_range(0, 127))});
        if ($urandom_range(0, 9) < 6) begin
          st[7:4] = 4'($urandom_range(8, 14));
        end else begin
          st[7:4] = 4'hF;
        end
        st[3:0] = 4'($urandom_range(0, 15));
        pkt.push_back(st);
        k = $urandom_range(0, 99);
        n = (k < 70) ? $urandom_range(0, 3) : (k < 95) ? $urandom_range(4, 8)
                                                       : $urandom_range(9, 14);
        for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 127)));
      end
    end else if (shape < 90) begin
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(8'($urandom_range(0, 127)));
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
    end else if (shape < 95) begin
      if ($urandom_range(0, 1) == 1) pkt.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 7);
      for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
    end
    foreach (pkt[i]) push_word(pkt[i], i == pkt.size() - 1);
  endtask

  // Sender: a word stays on the bus until it is taken.
  always @(negedge clk) begin
    word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken_now) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w.value;
        s_axis_tlast <= w.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off so that the decoder backs up into its input.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!stall_done && words_taken >= 300) begin
      stall_left <= 300;
      stall_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    msg_t got;
    msg_t want;
    word_taken_now = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_msgs.size() == 0) begin
          if (bad_count < 10) $display("unexpected message: status %h d1 %h d2 %h len %0d",
                                       got.status, got.data_first, got.data_second, got.length);
          bad_count++;
        end else begin
          want = expected_msgs.pop_front();
          if (got.status !== want.status || got.data_first !== want.data_first ||
              got.data_second !== want.data_second || got.length !== want.length) begin
            if (bad_count < 10) begin
              $display("mismatch: expected status %h d1 %h d2 %h len %0d", want.status,
                       want.data_first, want.data_second, want.length);
              $display("          got      status %h d1 %h d2 %h len %0d", got.status,
                       got.data_first, got.data_second, got.length);
            end
            bad_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        word_taken_now = 1'b1;
        decode_word(s_axis_tdata, s_axis_tlast);
        words_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_ble_midi_packet_decoder_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int target;
    push_word(8'h80, 1'b0); push_word(8'h80, 1'b0); push_word({HI_NOTE_ON, 4'h0}, 1'b0);
    push_word(8'h3C, 1'b0); push_word(8'h7F, 1'b1);
    push_word(8'hBF, 1'b0); push_word(8'hFF, 1'b0); push_word({HI_PROGRAM, 4'h5}, 1'b1);
    push_word(8'h80, 1'b0); push_word(8'h81, 1'b0); push_word({HI_CHAN_AT, 4'h3}, 1'b0);
    push_word(8'h00, 1'b0); push_word(8'h7F, 1'b0); push_word(8'h85, 1'b0);
    push_word(SYS_SONG_POS, 1'b0); push_word(8'h01, 1'b0); push_word(8'h02, 1'b0);
    push_word(8'h80, 1'b0); push_word(SYS_TUNE, 1'b0); push_word(8'h81, 1'b0);
    push_word(SYS_UNDEFINED, 1'b1);
    push_word(8'h80, 1'b0); push_word(8'h80, 1'b0); push_word(8'h12, 1'b1);
    push_word(8'h80, 1'b1);
    target = words_queued + PHASE_WORDS;
    while (words_queued < target) queue_random_packet();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        send_idle_pct = 51;
        recv_idle_pct = 10;
      end else if (p == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p > 0) begin
        target = words_queued + PHASE_WORDS;
        while (words_queued < target) queue_random_packet();
      end
      while (words_taken != words_queued || expected_msgs.size() != 0) @(negedge clk);
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (bad_count == 0 && expected_msgs.size() == 0) begin
      $display("tb_ble_midi_packet_decoder_top OK");
    end else begin
      $display("tb_ble_midi_packet_decoder_top NOT OK");
    end
    $finish;
  end

endmodule
